>>> design/palette_nearest_color_match_core_defines.svh
// Assertion macros for the palette nearest color match core.
`ifndef PALETTE_NEAREST_COLOR_MATCH_CORE_DEFINES_SVH
`define PALETTE_NEAREST_COLOR_MATCH_CORE_DEFINES_SVH

`ifndef ASSERT_OFF
`define PNCM_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PNCM_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PNCM_ASSERT(lbl, clk, rst, prop, msg)
`define PNCM_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

>>> design/pncm_pkg.sv
// Shared types, constants and helpers for the palette nearest color match core.
`default_nettype none
package pncm_pkg;

  localparam int PALETTE_ENTRIES_DEF = 256;
  localparam int IDX_W   = 8;
  localparam int CH_W    = 8;
  localparam int RGB_W   = 3 * CH_W;
  localparam int SQ_W    = 2 * CH_W;
  localparam int DIST_W  = 18;
  localparam int COLOR_W = 32;

  localparam logic [IDX_W-1:0] TRANSPARENT_IDX = 8'd255;
  localparam logic [CH_W-1:0]  ALPHA_OPAQUE    = 8'hFF;
  localparam logic [CH_W-1:0]  ALPHA_CLEAR     = 8'h00;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic             valid;
    logic             last;
    logic [IDX_W-1:0] idx;
  } tag_t;

  function automatic logic [CH_W-1:0] expand5(input logic [4:0] c);
    expand5 = {c, 3'b100};
  endfunction

endpackage
`default_nettype wire

>>> design/pncm_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module pncm_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

>>> design/pncm_dist.sv
// Shared squared RGB distance unit: registered channel squares, then the sum.
`default_nettype none
module pncm_dist (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic [pncm_pkg::CH_W-1:0]    qr,
  input  wire logic [pncm_pkg::CH_W-1:0]    qg,
  input  wire logic [pncm_pkg::CH_W-1:0]    qb,
  input  wire logic [pncm_pkg::RGB_W-1:0]   entry,
  input  wire logic                         entry_valid,
  input  wire pncm_pkg::tag_t               tag_in,
  output logic      [pncm_pkg::DIST_W-1:0]  dist_sum,
  output pncm_pkg::tag_t                    tag_out
);

  logic [pncm_pkg::RGB_W-1:0] ent;
  logic [pncm_pkg::CH_W-1:0]  dr, dg, db;
  logic [pncm_pkg::SQ_W-1:0]  sq_r, sq_g, sq_b;

  function automatic logic [pncm_pkg::CH_W-1:0] absdiff(
    input logic [pncm_pkg::CH_W-1:0] a,
    input logic [pncm_pkg::CH_W-1:0] b
  );
    absdiff = (a >= b) ? (a - b) : (b - a);
  endfunction

  assign ent = entry_valid ? entry : '0;
  assign dr  = absdiff(qr, ent[7:0]);
  assign dg  = absdiff(qg, ent[15:8]);
  assign db  = absdiff(qb, ent[23:16]);

  always_ff @(posedge clk) begin
    sq_r <= dr * dr;
    sq_g <= dg * dg;
    sq_b <= db * db;
    if (rst) begin
      tag_out <= '0;
    end else begin
      tag_out <= tag_in;
    end
  end

  assign dist_sum = pncm_pkg::DIST_W'(sq_r) + pncm_pkg::DIST_W'(sq_g)
                  + pncm_pkg::DIST_W'(sq_b);

endmodule
`default_nettype wire

>>> design/palette_nearest_color_match_core.sv
// Top level of the palette nearest color match core: sequencer, palette and best tracker.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | input     | in_valid / in_stall  | func, entry_index, red, green, blue, color15
//  out     | output    | out_valid / out_stall| packed_color, nearest_index, best_distance
//
// A load is held off while a query runs, and in idle while a result waits and out is stalled.
// A query reads one palette entry per cycle, then passes each through the RAM read,
// square and compare stages.
// Reset clears valid bits for every entry, so unwritten entries read as zero at once.
// While a query runs in_stall stays high; a finished query waits for out to free up.
`default_nettype none
`include "palette_nearest_color_match_core_defines.svh"
module palette_nearest_color_match_core #(
  parameter int PALETTE_ENTRIES = pncm_pkg::PALETTE_ENTRIES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          func,
  input  wire logic [pncm_pkg::IDX_W-1:0]    entry_index,
  input  wire logic [pncm_pkg::CH_W-1:0]     red,
  input  wire logic [pncm_pkg::CH_W-1:0]     green,
  input  wire logic [pncm_pkg::CH_W-1:0]     blue,
  input  wire logic [14:0]                   color15,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic      [pncm_pkg::COLOR_W-1:0]  packed_color,
  output logic      [pncm_pkg::IDX_W-1:0]    nearest_index,
  output logic      [pncm_pkg::DIST_W-1:0]   best_distance
);

  localparam int AW = $clog2(PALETTE_ENTRIES);

  pncm_pkg::state_t state, state_next;

  logic                          in_acc;
  logic                          load_acc;
  logic                          query_acc;
  logic                          out_free;
  logic                          scan_issue;
  logic                          scan_last;
  logic                          out_load_query;
  logic                          wr_ok;
  logic [AW-1:0]                 scan_cnt;
  logic [PALETTE_ENTRIES-1:0]    ent_valid;
  logic                          s1_ent_valid;
  logic [pncm_pkg::RGB_W-1:0]    s1_entry;
  pncm_pkg::tag_t                s1_tag;
  pncm_pkg::tag_t                s2_tag;
  logic [pncm_pkg::DIST_W-1:0]   s2_dist;
  logic [pncm_pkg::CH_W-1:0]     qr, qg, qb;
  logic [pncm_pkg::DIST_W-1:0]   best_d;
  logic [pncm_pkg::IDX_W-1:0]    best_i;
  logic [pncm_pkg::CH_W-1:0]     alpha;

  assign in_acc    = in_valid && !in_stall;
  assign load_acc  = in_acc && (func == pncm_pkg::FUNC_LOAD);
  assign query_acc = in_acc && (func == pncm_pkg::FUNC_QUERY);
  assign out_free  = !out_valid || !out_stall;
  assign scan_last = (scan_cnt == AW'(PALETTE_ENTRIES - 1));
  assign wr_ok     = ({1'b0, entry_index} < 9'(PALETTE_ENTRIES));
  assign alpha     = (entry_index == pncm_pkg::TRANSPARENT_IDX) ?
                     pncm_pkg::ALPHA_CLEAR : pncm_pkg::ALPHA_OPAQUE;

  always_comb begin
    state_next = state;
    case (state)
      pncm_pkg::ST_IDLE: if (query_acc) state_next = pncm_pkg::ST_SCAN;
      pncm_pkg::ST_SCAN: if (scan_last) state_next = pncm_pkg::ST_WAIT;
      pncm_pkg::ST_WAIT: if (s2_tag.valid && s2_tag.last) state_next = pncm_pkg::ST_DONE;
      pncm_pkg::ST_DONE: if (out_free) state_next = pncm_pkg::ST_IDLE;
      default:           state_next = pncm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall       = 1'b1;
    scan_issue     = 1'b0;
    out_load_query = 1'b0;
    case (state)
      pncm_pkg::ST_IDLE: in_stall = (func == pncm_pkg::FUNC_LOAD) && !out_free;
      pncm_pkg::ST_SCAN: scan_issue = 1'b1;
      pncm_pkg::ST_WAIT: scan_issue = 1'b0;
      pncm_pkg::ST_DONE: out_load_query = out_free;
      default:           in_stall = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= pncm_pkg::ST_IDLE;
      scan_cnt  <= '0;
      ent_valid <= '0;
      s1_tag    <= '0;
    end else begin
      state <= state_next;
      if (query_acc) begin
        scan_cnt <= '0;
      end else if (scan_issue && !scan_last) begin
        scan_cnt <= scan_cnt + 1'b1;
      end
      if (load_acc && wr_ok) begin
        ent_valid[entry_index[AW-1:0]] <= 1'b1;
      end
      s1_tag.valid <= scan_issue;
      s1_tag.last  <= scan_last;
      s1_tag.idx   <= pncm_pkg::IDX_W'(scan_cnt);
    end
  end

  always_ff @(posedge clk) begin
    s1_ent_valid <= ent_valid[scan_cnt];
    if (query_acc) begin
      qr <= pncm_pkg::expand5(color15[4:0]);
      qg <= pncm_pkg::expand5(color15[9:5]);
      qb <= pncm_pkg::expand5(color15[14:10]);
    end
    if (s2_tag.valid && (s2_tag.idx == '0 || s2_dist < best_d)) begin
      best_d <= s2_dist;
      best_i <= s2_tag.idx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_acc || out_load_query) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_acc) begin
      packed_color  <= {alpha, blue, green, red};
      nearest_index <= '0;
      best_distance <= '0;
    end else if (out_load_query) begin
      packed_color  <= '0;
      nearest_index <= best_i;
      best_distance <= best_d;
    end
  end

  pncm_ram #(
    .WIDTH(pncm_pkg::RGB_W),
    .DEPTH(PALETTE_ENTRIES)
  ) u_ram (
    .clk  (clk),
    .we   (load_acc && wr_ok),
    .waddr(entry_index[AW-1:0]),
    .wdata({blue, green, red}),
    .raddr(scan_cnt),
    .rdata(s1_entry)
  );

  pncm_dist u_dist (
    .clk        (clk),
    .rst        (rst),
    .qr         (qr),
    .qg         (qg),
    .qb         (qb),
    .entry      (s1_entry),
    .entry_valid(s1_ent_valid),
    .tag_in     (s1_tag),
    .dist_sum   (s2_dist),
    .tag_out    (s2_tag)
  );

  `PNCM_ASSERT(a_query_starts_scan, clk, rst, query_acc |=> (state == pncm_pkg::ST_SCAN), "query transaction did not start a scan")
  `PNCM_ASSERT(a_tag_in_query, clk, rst, s2_tag.valid |-> (state == pncm_pkg::ST_SCAN || state == pncm_pkg::ST_WAIT), "distance stage active outside a query")
  `PNCM_ASSERT(a_result_kind, clk, rst, out_valid |-> (packed_color == '0 || (nearest_index == '0 && best_distance == '0)), "result mixes load and query fields")

endmodule
`default_nettype wire

>>> verif/tb_palette_nearest_color_match_core.sv
// Self-checking testbench for the palette nearest color match core: palette loads and nearest-color queries.
module tb_palette_nearest_color_match_core;
  import pncm_pkg::*;

  localparam int     PAL_N        = PALETTE_ENTRIES_DEF;
  localparam int     NUM_RANDOM   = 1825;
  localparam int     DRAIN_CYCLES = PAL_N + 40;
  localparam longint CYCLE_LIMIT  = 3_000_000;
  localparam int     PRINT_CAP    = 30;
  localparam logic   LD           = FUNC_LOAD;
  localparam logic   QY           = FUNC_QUERY;

  typedef struct packed {
    logic             func;
    logic [IDX_W-1:0] idx;
    logic [CH_W-1:0]  r;
    logic [CH_W-1:0]  g;
    logic [CH_W-1:0]  b;
    logic [14:0]      c15;
  } palette_txn_t;

  typedef struct packed {
    logic [COLOR_W-1:0] color;
    logic [IDX_W-1:0]   index;
    logic [DIST_W-1:0]  distance;
  } match_t;

  typedef struct packed {
    palette_txn_t txn;
    logic         typed;
    match_t       want;
  } dir_row_t;

  localparam int NUM_DIR = 25;

  dir_row_t dir_rows [NUM_DIR] = '{
    '{'{QY, 8'd0,   8'h00, 8'h00, 8'h00, 15'h0000}, 1'b1, '{32'h0, 8'd0, 18'd48}},
    '{'{QY, 8'd0,   8'h00, 8'h00, 8'h00, 15'h7FFF}, 1'b1, '{32'h0, 8'd0, 18'd190512}},
    '{'{LD, 8'd0,   8'hFF, 8'hFF, 8'hFF, 15'h0000}, 1'b1, '{32'hFFFFFFFF, 8'd0, 18'd0}},
    '{'{LD, 8'd255, 8'h12, 8'h34, 8'h56, 15'h7FFF}, 1'b1, '{32'h00563412, 8'd0, 18'd0}},
    '{'{LD, 8'd128, 8'h00, 8'h00, 8'h00, 15'h5555}, 1'b1, '{32'hFF000000, 8'd0, 18'd0}},
    '{'{QY, 8'd0,   8'h00, 8'h00, 8'h00, 15'h7FFF}, 1'b1, '{32'h0, 8'd0, 18'd27}},
    '{'{QY, 8'd0,   8'h00, 8'h00, 8'h00, 15'h0000}, 1'b1, '{32'h0, 8'd1, 18'd48}},
    '{'{LD, 8'd255, 8'h04, 8'h04, 8'h04, 15'h2AAA}, 1'b1, '{32'h00040404, 8'd0, 18'd0}},
    '{'{QY, 8'd0,   8'h00, 8'h00, 8'h00, 15'h0000}, 1'b1, '{32'h0, 8'd255, 18'd0}},
    '{'{QY, 8'd0,   8'h00, 8'h00, 8'h00, 15'h001F}, 1'b0, '0},
    '{'{LD, 8'd10,  8'h64, 8'h64, 8'h64, 15'h0000}, 1'b1, '{32'hFF646464, 8'd0, 18'd0}},
    '{'{LD, 8'd20,  8'h64, 8'h64, 8'h64, 15'h0000}, 1'b1, '{32'hFF646464, 8'd0, 18'd0}},
    '{'{QY, 8'd0,   8'h00, 8'h00, 8'h00, 15'h318C}, 1'b1, '{32'h0, 8'd10, 18'd0}},
    '{'{LD, 8'd10,  8'h68, 8'h64, 8'h64, 15'h0000}, 1'b0, '0},
    '{'{LD, 8'd30,  8'h60, 8'h64, 8'h64, 15'h0000}, 1'b0, '0},
    '{'{QY, 8'd0,   8'h00, 8'h00, 8'h00, 15'h318C}, 1'b0, '0},
    '{'{LD, 8'd20,  8'h00, 8'h00, 8'h00, 15'h0000}, 1'b0, '0},
    '{'{QY, 8'd0,   8'h00, 8'h00, 8'h00, 15'h318C}, 1'b0, '0},
    '{'{LD, 8'd1,   8'hFF, 8'h00, 8'h00, 15'h0000}, 1'b1, '{32'hFF0000FF, 8'd0, 18'd0}},
    '{'{LD, 8'd2,   8'h00, 8'hFF, 8'h00, 15'h0000}, 1'b1, '{32'hFF00FF00, 8'd0, 18'd0}},
    '{'{LD, 8'd3,   8'h00, 8'h00, 8'hFF, 15'h0000}, 1'b1, '{32'hFFFF0000, 8'd0, 18'd0}},
    '{'{QY, 8'd0,   8'h00, 8'h00, 8'h00, 15'h001F}, 1'b0, '0},
    '{'{QY, 8'd0,   8'h00, 8'h00, 8'h00, 15'h03E0}, 1'b0, '0},
    '{'{QY, 8'd0,   8'h00, 8'h00, 8'h00, 15'h7C00}, 1'b0, '0},
    '{'{LD, 8'd254, 8'hAA, 8'h55, 8'hA5, 15'h0000}, 1'b0, '0}
  };

  logic               clk         = 1'b0;
  logic               rst         = 1'b1;
  logic               in_valid    = 1'b0;
  logic               in_stall;
  logic               func        = 1'b0;
  logic [IDX_W-1:0]   entry_index = '0;
  logic [CH_W-1:0]    red         = '0;
  logic [CH_W-1:0]    green       = '0;
  logic [CH_W-1:0]    blue        = '0;
  logic [14:0]        color15     = '0;
  logic               out_valid;
  logic               out_stall   = 1'b0;
  logic [COLOR_W-1:0] packed_color;
  logic [IDX_W-1:0]   nearest_index;
  logic [DIST_W-1:0]  best_distance;

  logic [RGB_W-1:0] pal_rgb [PAL_N];
  match_t           pending_matches [$];
  int               err_cnt     = 0;
  int               checked_cnt = 0;
  int               load_cnt    = 0;
  int               query_cnt   = 0;
  int               exact_cnt   = 0;
  int               tie_cnt     = 0;
  longint           cycle_cnt   = 0;
  bit               burst_in    = 1'b0;
  bit               burst_out   = 1'b0;

  palette_nearest_color_match_core #(
    .PALETTE_ENTRIES(PAL_N)
  ) i_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .func         (func),
    .entry_index  (entry_index),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .color15      (color15),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .packed_color (packed_color),
    .nearest_index(nearest_index),
    .best_distance(best_distance)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt = cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_matches.size());
      $display("Verification failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    err_cnt++;
    if (err_cnt <= PRINT_CAP) $display("MISMATCH cycle %0d: %s", cycle_cnt, msg);
  endtask

  function automatic match_t predict_match(input palette_txn_t t);
    match_t m;
    int     q [3];
    int     d;
    int     diff;
    int     best_d;
    int     best_i;
    bit     tied;
    m = '0;
    if (t.func == FUNC_LOAD) begin
      m.color = {(t.idx == TRANSPARENT_IDX) ? ALPHA_CLEAR : ALPHA_OPAQUE, t.b, t.g, t.r};
      if (int'(t.idx) < PAL_N) pal_rgb[t.idx] = {t.b, t.g, t.r};
      load_cnt++;
    end else begin
      for (int k = 0; k < 3; k++) q[k] = ((int'(t.c15) >> (5 * k)) & 31) * 8 + 4;
      best_d = 0;
      best_i = 0;
      tied   = 1'b0;
      for (int v = 0; v < PAL_N; v++) begin
        d = 0;
        for (int k = 0; k < 3; k++) begin
          diff = q[k] - int'(pal_rgb[v][8*k +: 8]);
          d += diff * diff;
        end
        if (v == 0 || d < best_d) begin
          best_d = d;
          best_i = v;
          tied   = 1'b0;
        end else if (d == best_d) begin
          tied = 1'b1;
        end
      end
      m.index    = IDX_W'(best_i);
      m.distance = DIST_W'(best_d);
      query_cnt++;
      if (best_d == 0) exact_cnt++;
      if (tied) tie_cnt++;
    end
    return m;
  endfunction

  function automatic palette_txn_t rand_txn();
    palette_txn_t     t;
    logic [RGB_W-1:0] src;
    int               pick;
    t.func = ($urandom_range(0, 99) < 62) ? FUNC_LOAD : FUNC_QUERY;
    t.idx  = IDX_W'($urandom);
    t.r    = CH_W'($urandom);
    t.g    = CH_W'($urandom);
    t.b    = CH_W'($urandom);
    t.c15  = 15'($urandom);
    src    = pal_rgb[$urandom_range(0, PAL_N - 1)];
    pick   = $urandom_range(0, 3);
    if (t.func == FUNC_LOAD) begin
      if (pick == 0) begin
        {t.b, t.g, t.r} = src;
      end else if (pick == 1) begin
        {t.b, t.g, t.r} = {5'($urandom), 3'b100, 5'($urandom), 3'b100, 5'($urandom), 3'b100};
      end
    end else if (pick < 2) begin
      t.c15 = {src[23:19], src[15:11], src[7:3]};
      if (pick == 1) t.c15 = t.c15 ^ (15'd1 << $urandom_range(0, 14));
    end
    return t;
  endfunction

  task automatic send_txn(input palette_txn_t t, input bit typed, input match_t want);
    int     gap;
    match_t m;
    gap = burst_in ? 0 : $urandom_range(0, 5);
    if ($urandom_range(0, 39) == 0) burst_in = !burst_in;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    func        <= t.func;
    entry_index <= t.idx;
    red         <= t.r;
    green       <= t.g;
    blue        <= t.b;
    color15     <= t.c15;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    m = predict_match(t);
    pending_matches.push_back(typed ? want : m);
  endtask

  task automatic check_result();
    match_t want;
    if (pending_matches.size() == 0) begin
      report_mismatch($sformatf("unexpected transaction: color %h index %0d distance %0d",
                                packed_color, nearest_index, best_distance));
    end else begin
      want = pending_matches.pop_front();
      checked_cnt++;
      if (packed_color !== want.color)
        report_mismatch($sformatf("packed_color %h, want %h", packed_color, want.color));
      if (nearest_index !== want.index)
        report_mismatch($sformatf("nearest_index %0d, want %0d", nearest_index, want.index));
      if (best_distance !== want.distance)
        report_mismatch($sformatf("best_distance %0d, want %0d", best_distance,
                                  want.distance));
    end
  endtask

  initial begin
    int n;
    wait (rst == 1'b0);
    forever begin
      n = burst_out ? 0 : $urandom_range(0, 5);
      if ($urandom_range(0, 39) == 0) burst_out = !burst_out;
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      check_result();
    end
  end

  initial begin
    for (int v = 0; v < PAL_N; v++) pal_rgb[v] = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int i = 0; i < NUM_DIR; i++)
      send_txn(dir_rows[i].txn, dir_rows[i].typed, dir_rows[i].want);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if (i == NUM_RANDOM / 2) begin
        // hold off until the pipeline is empty
        in_valid <= 1'b0;
        do @(posedge clk); while (pending_matches.size() != 0);
      end
      send_txn(rand_txn(), 1'b0, '0);
    end
    in_valid <= 1'b0;
    while (pending_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_matches.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_matches.size()));
    $display("Ran %0d palette loads and %0d nearest-color queries, %0d results checked",
             load_cnt, query_cnt, checked_cnt);
    $display("Queries with an exact palette hit: %0d, with tied candidates: %0d, errors: %0d",
             exact_cnt, tie_cnt, err_cnt);
    if (err_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
